// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the frame deframer.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed: cond");

// Check that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(name, trig, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("assertion failed: trig then cond");

`endif

// ===== src/ipd_pkg.sv =====
// Package of the +IPD frame deframer: phase codes, item types, prefix table.
// Depends on nothing; used by the channel interfaces and the top level.
`default_nettype none

package ipd_pkg;

    localparam int unsigned LENGTH_MAX = 65535;
    localparam int unsigned PREFIX_LAST = 4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PREFIX,
        PH_LENGTH,
        PH_DATA
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_item;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        message_done;
        logic [15:0] message_length;
    } t_res_item;

    // Expected prefix character at a position; positions outside the prefix give 0.
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = CH_PLUS;
            3'd1:    ch = CH_I;
            3'd2:    ch = CH_P;
            3'd3:    ch = CH_D;
            3'd4:    ch = CH_COMMA;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== src/ipd_stream_if.sv =====
// Valid/ready channels of the deframer: received bytes in, results out.
// Depends on ipd_pkg for the payload types.
`default_nettype none

interface ipd_rx_if import ipd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_rx_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ipd_res_if import ipd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_res_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/ipd_frame_deframer.sv =====
// +IPD frame deframer: one received byte in, one result out per transfer.
// Each byte passes the input reg, then the result reg; a stalled result can hold it in either.
// Throughput: 1 byte per cycle while o_res.ready is high; the parser update is combinational.
// Reset (i_rst_n low, synchronous): both stages empty, parser idle, counters zero.
// Depends on ipd_pkg, ipd_rx_if / ipd_res_if and assert_macros.svh.
// Results stall in place while o_res.ready is low; an empty input stage still takes a byte.
`default_nettype none
`include "assert_macros.svh"

module ipd_frame_deframer import ipd_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ipd_rx_if.sink     i_rx,
    ipd_res_if.source  o_res
);

    // Pipeline control
    logic      r_s1_vld;
    logic [7:0] r_s1_byte;
    logic      r_out_vld;
    t_res_item r_res;
    logic      out_free;
    logic      s1_move;

    // Parser state
    t_phase      r_phase,  n_phase;
    logic [2:0]  r_pos,    n_pos;
    logic [15:0] r_len,    n_len;
    logic [15:0] r_cnt,    n_cnt;
    t_res_item   n_res;

    // Datapath helpers
    logic        is_digit;
    logic        pos_ok;
    logic [19:0] len_acc;
    logic [15:0] len_sat;
    logic        below;
    logic [15:0] cnt_inc;
    logic [15:0] cnt_after;

    // The result register frees when empty or when its transfer completes;
    // stage 1 moves into it then, and takes a new byte in the same cycle.
    assign out_free   = !r_out_vld || o_res.ready;
    assign s1_move    = r_s1_vld && out_free;
    assign i_rx.ready = !r_s1_vld || out_free;
    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_res;

    // Length accumulate: len*10 + digit as two shifts and an add, then saturate.
    assign is_digit = (r_s1_byte >= CH_ZERO) && (r_s1_byte <= CH_NINE);
    assign len_acc  = {1'b0, r_len, 3'b000} + {3'b000, r_len, 1'b0}
                    + {12'd0, r_s1_byte - CH_ZERO};
    assign len_sat  = (len_acc > 20'(LENGTH_MAX)) ? 16'(LENGTH_MAX) : len_acc[15:0];

    // Payload counting
    assign below     = r_cnt < r_len;
    assign cnt_inc   = r_cnt + 16'd1;
    assign cnt_after = below ? cnt_inc : r_cnt;

    assign pos_ok = (r_pos >= 3'd1) && (r_pos <= 3'(PREFIX_LAST));

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_res   = '0;

        unique case (r_phase)
            PH_IDLE: begin
                // Wait for the frame start.
                if (r_s1_byte == CH_PLUS) begin
                    n_phase = PH_PREFIX;
                    n_pos   = 3'd1;
                end
            end
            PH_PREFIX: begin
                // Match the rest of the prefix; drop back on any mismatch
                // without retrying the byte as a frame start.
                if (pos_ok && r_s1_byte == prefix_char(r_pos)) begin
                    if (r_pos == 3'(PREFIX_LAST)) begin
                        n_phase = PH_LENGTH;
                    end else begin
                        n_pos = r_pos + 3'd1;
                    end
                end else begin
                    n_phase = PH_IDLE;
                    n_pos   = 3'd0;
                end
            end
            PH_LENGTH: begin
                n_res.message_length = r_len;
                if (is_digit) begin
                    n_len                = len_sat;
                    n_res.message_length = len_sat;
                end else if (r_s1_byte == CH_COLON) begin
                    n_phase = PH_DATA;
                    n_cnt   = 16'd0;
                end else begin
                    // Abort the frame and clear the length.
                    n_phase = PH_IDLE;
                    n_len   = 16'd0;
                end
            end
            PH_DATA: begin
                n_res.message_length = r_len;
                if (below) begin
                    n_res.payload_valid = 1'b1;
                    n_res.payload_byte  = r_s1_byte;
                    n_res.payload_index = r_cnt;
                end
                n_cnt = cnt_after;
                // A zero length frame ends here on the first byte with no payload.
                if (cnt_after == r_len) begin
                    n_res.message_done = 1'b1;
                    n_phase = PH_IDLE;
                    n_len   = 16'd0;
                    n_cnt   = 16'd0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase   <= PH_IDLE;
            r_pos     <= 3'd0;
            r_len     <= 16'd0;
            r_cnt     <= 16'd0;
        end else begin
            // Input stage: hold while blocked, refill on transfer.
            if (i_rx.valid && i_rx.ready) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            // Result stage: load when stage 1 advances, drain on transfer.
            if (s1_move) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            // Commit parser state only as the byte moves to the result.
            if (s1_move) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_len   <= n_len;
                r_cnt   <= n_cnt;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_s1_byte <= i_rx.data.rx_byte;
        end
        if (s1_move) begin
            r_res <= n_res;
        end
    end

    // The length stays clear until the prefix is matched.
    `ASSERT_ALWAYS(a_len_clear_outside_frame,
        (r_phase != PH_IDLE && r_phase != PH_PREFIX) || r_len == 16'd0)

    // The payload count never passes the declared length.
    `ASSERT_ALWAYS(a_cnt_bounded, r_cnt <= r_len)

    // A payload byte sits inside the declared length; the last one closes the frame.
    `ASSERT_ALWAYS(a_index_in_range,
        !(r_out_vld && r_res.payload_valid) ||
        (r_res.payload_index < r_res.message_length))
    `ASSERT_ALWAYS(a_done_on_last,
        !(r_out_vld && r_res.payload_valid && r_res.message_done) ||
        ((17'(r_res.payload_index) + 17'd1) == 17'(r_res.message_length)))

    // A colon after the length opens the payload with the count at zero.
    `ASSERT_NEXT(a_colon_opens_payload,
        s1_move && r_phase == PH_LENGTH && r_s1_byte == CH_COLON,
        r_phase == PH_DATA && r_cnt == 16'd0)

endmodule

`default_nettype wire

// ===== tb/sv/ipd_deframer_checker.sv =====
// Scoreboard of the +IPD frame deframer: follows both channels, predicts
// each result from the accepted bytes, and compares it field by field.
// Depends on ipd_pkg and the ipd_rx_if / ipd_res_if channel interfaces.
module ipd_deframer_checker import ipd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipd_rx_if           i_rx,
    ipd_res_if          i_res,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // "+IPD," packed with position 0 in the low byte
    localparam logic [39:0] IPD_TAG = {CH_COMMA, CH_D, CH_P, CH_I, CH_PLUS};

    t_phase      parse_phase;
    logic [2:0]  tag_pos;
    logic [15:0] length_acc;
    logic [15:0] payload_seen;
    t_res_item   awaited_results[$];

    function automatic t_res_item deframe_byte(input logic [7:0] b);
        t_res_item   r;
        int unsigned grown;
        r = '0;
        case (parse_phase)
            PH_IDLE: begin
                if (b == CH_PLUS) begin
                    parse_phase = PH_PREFIX;
                    tag_pos     = 3'd1;
                end
            end
            PH_PREFIX: begin
                if (tag_pos >= 3'd1 && tag_pos <= 3'(PREFIX_LAST) &&
                    b == IPD_TAG[8*tag_pos +: 8]) begin
                    if (tag_pos == 3'(PREFIX_LAST)) parse_phase = PH_LENGTH;
                    else tag_pos = tag_pos + 3'd1;
                end else begin
                    parse_phase = PH_IDLE;
                    tag_pos     = 3'd0;
                end
            end
            PH_LENGTH: begin
                r.message_length = length_acc;
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    grown = 32'(length_acc) * 10 + 32'(b - CH_ZERO);
                    if (grown > LENGTH_MAX) grown = LENGTH_MAX;
                    length_acc       = grown[15:0];
                    r.message_length = length_acc;
                end else if (b == CH_COLON) begin
                    parse_phase  = PH_DATA;
                    payload_seen = '0;
                end else begin
                    parse_phase = PH_IDLE;
                    length_acc  = '0;
                end
            end
            default: begin
                r.message_length = length_acc;
                if (payload_seen < length_acc) begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    r.payload_index = payload_seen;
                    payload_seen    = payload_seen + 16'd1;
                end
                if (payload_seen == length_acc) begin
                    r.message_done = 1'b1;
                    parse_phase    = PH_IDLE;
                    length_acc     = '0;
                    payload_seen   = '0;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_res_item want;
        if (!i_rst_n) begin
            parse_phase  = PH_IDLE;
            tag_pos      = '0;
            length_acc   = '0;
            payload_seen = '0;
            awaited_results.delete();
        end else begin
            // Compare the outgoing result first: it always stems from an older byte.
            if (i_res.valid && i_res.ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with nothing awaited",
                                    {8'h00, i_res.data.payload_byte}, 16'd0);
                end else begin
                    want = awaited_results.pop_front();
                    if (i_res.data.payload_valid !== want.payload_valid)
                        report_mismatch("payload_valid", i_res.data.payload_valid,
                                        want.payload_valid);
                    if (i_res.data.payload_byte !== want.payload_byte)
                        report_mismatch("payload_byte", i_res.data.payload_byte,
                                        want.payload_byte);
                    if (i_res.data.payload_index !== want.payload_index)
                        report_mismatch("payload_index", i_res.data.payload_index,
                                        want.payload_index);
                    if (i_res.data.message_done !== want.message_done)
                        report_mismatch("message_done", i_res.data.message_done,
                                        want.message_done);
                    if (i_res.data.message_length !== want.message_length)
                        report_mismatch("message_length", i_res.data.message_length,
                                        want.message_length);
                end
            end
            if (i_rx.valid && i_rx.ready)
                awaited_results.push_back(deframe_byte(i_rx.data.rx_byte));
        end
        o_pending = awaited_results.size();
    end
endmodule

// ===== tb/sv/testbench.sv =====
// Top of the +IPD frame deframer testbench: clock, reset, byte stimulus,
// result back-pressure, watchdog and verdict.
// Depends on ipd_pkg, the channel interfaces, the deframer and ipd_deframer_checker.
module testbench;
    import ipd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT  = 2000; // cycles with no transfer at all
    localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
    localparam int unsigned RANDOM_BYTES = 1200;

    logic        clk;
    logic        rst_n;
    logic        idle_on;       // random gaps on both sides when set
    logic        hold_request;  // ask the receiver for one long hold-off
    int unsigned hold_left;
    int unsigned bytes_sent;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned stall_cycles;

    ipd_rx_if  rx_ch();
    ipd_res_if res_ch();

    ipd_frame_deframer DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    ipd_deframer_checker scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_rx         (rx_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Offer one byte from a falling edge and hold it until the transfer.
    // Valid stays high on return so back-to-back bytes need no extra step.
    task automatic send_byte(input logic [7:0] b);
        while (idle_on && $urandom_range(0, 99) < 33) begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid        <= 1'b1;
        rx_ch.data.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_prefix();
        send_byte(CH_PLUS);
        send_byte(CH_I);
        send_byte(CH_P);
        send_byte(CH_D);
        send_byte(CH_COMMA);
    endtask

    // Send a length in decimal, most significant digit first.
    task automatic send_decimal(input int unsigned value, input int unsigned zeros);
        logic [7:0]  digits[$];
        int unsigned rest;
        rest = value;
        do begin
            digits.push_front(CH_ZERO + 8'(rest % 10));
            rest = rest / 10;
        end while (rest != 0);
        repeat (zeros) send_byte(CH_ZERO);
        foreach (digits[k]) send_byte(digits[k]);
    endtask

    // Any byte that neither extends the length nor opens the payload.
    function automatic logic [7:0] pick_abort_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COLON);
        return b;
    endfunction

    task automatic send_good_frame();
        int unsigned len;
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 16)
                                            : $urandom_range(17, 300);
        send_prefix();
        // Leave out the digits now and then: an empty length reads as zero.
        if (!(len == 0 && $urandom_range(0, 1) == 1))
            send_decimal(len, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
        send_byte(CH_COLON);
        // A zero length still eats one byte to close the frame.
        repeat ((len == 0) ? 1 : len) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_broken_frame();
        int unsigned cut;
        logic [7:0]  wrong;
        logic [7:0]  right;
        case ($urandom_range(0, 2))
            0: begin
                // Break the prefix at a random position.
                cut = $urandom_range(1, PREFIX_LAST);
                send_byte(CH_PLUS);
                if (cut > 1) send_byte(CH_I);
                if (cut > 2) send_byte(CH_P);
                if (cut > 3) send_byte(CH_D);
                case (cut)
                    1:       right = CH_I;
                    2:       right = CH_P;
                    3:       right = CH_D;
                    default: right = CH_COMMA;
                endcase
                do wrong = 8'($urandom_range(0, 255)); while (wrong == right);
                send_byte(wrong);
            end
            1: begin
                // Abort inside the length, sometimes after it has saturated.
                send_prefix();
                if ($urandom_range(0, 3) != 0)
                    send_decimal(($urandom_range(0, 1) == 1) ? $urandom_range(0, 999)
                                                              : $urandom_range(60000, 9999999), 0);
                send_byte(pick_abort_byte());
            end
            default: begin
                // Line noise.
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        res_ch.ready = 1'b0;
        hold_left    = 0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                res_ch.ready <= !(idle_on && $urandom_range(0, 99) < 33);
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long.
    initial begin
        stall_cycles = 0;
        wait (rst_n);
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        int unsigned frames;
        rst_n              = 1'b0;
        idle_on            = 1'b1;
        hold_request       = 1'b0;
        bytes_sent         = 0;
        frames             = 0;
        rx_ch.valid        = 1'b0;
        rx_ch.data.rx_byte = 8'h00;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: byte extremes while idle, a repeated plus that must not be
        // retaken as a frame start, an empty length, and a short frame.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_PLUS);
        send_byte(CH_PLUS);
        send_byte(CH_I);
        send_prefix();
        send_byte(CH_COLON);
        send_byte(8'hAA);
        send_prefix();
        send_byte(CH_ZERO + 8'd2);
        send_byte(CH_COLON);
        send_byte(8'hFF);
        send_byte(8'h00);

        // Random: mostly well-formed frames, the rest broken frames and noise.
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            frames++;
            // Request the long hold-off while bytes keep coming, to fill the pipe.
            if (frames == 15) hold_request = 1'b1;
            // Run a stretch with no gaps on either side.
            idle_on = !(frames >= 40 && frames < 70);
            if ($urandom_range(0, 99) < 70) send_good_frame();
            else send_broken_frame();
        end
        idle_on = 1'b1;

        // Saturate the length, then abort: the length clears on the abort.
        send_prefix();
        send_decimal(99999, 0);
        send_byte(pick_abort_byte());
        send_good_frame();

        rx_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== ipd_frame_deframer.f =====
+incdir+src
src/ipd_pkg.sv
src/ipd_stream_if.sv
src/ipd_frame_deframer.sv
tb/sv/ipd_deframer_checker.sv
tb/sv/testbench.sv
